@@ hdl/carc_pkg.sv @@
package carc_pkg;

  // Result event codes
  localparam logic [3:0] EV_TRANSMIT  = 4'd0;
  localparam logic [3:0] EV_SENT      = 4'd1;
  localparam logic [3:0] EV_FAILED    = 4'd2;
  localparam logic [3:0] EV_ACKWAIT   = 4'd3;
  localparam logic [3:0] EV_ACKED     = 4'd4;
  localparam logic [3:0] EV_TIMEOUT   = 4'd5;
  localparam logic [3:0] EV_RETRY     = 4'd6;
  localparam logic [3:0] EV_EXHAUSTED = 4'd7;
  localparam logic [3:0] EV_BUSY      = 4'd8;
  localparam logic [3:0] EV_NOACK     = 4'd9;

  // Request types
  localparam logic [1:0] REQ_SEND   = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_FRAME  = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACK_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_SEND_DELAY  = 3'd1;
  localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_BACKOFF     = 3'd3;
  localparam logic [2:0] CFG_RETRY_LIMIT = 3'd4;
  localparam logic [2:0] CFG_ACK_OFFSET  = 3'd5;

  localparam int unsigned MAX_EVENTS = 4;
  localparam logic [3:0]  DLC_FULL   = 4'd8;

  typedef struct packed {
    logic        ack_enable;
    logic [15:0] send_delay_ticks;
    logic [15:0] ack_timeout_ticks;
    logic [15:0] backoff_ticks;
    logic [7:0]  retry_limit;
    logic [28:0] ack_id_offset;
  } cfg_t;

  // Events produced by one request, handed to the emitter in one go
  typedef struct packed {
    logic [2:0]                    count;
    logic [MAX_EVENTS-1:0][3:0]    code;
    logic [MAX_EVENTS-1:0][7:0]    attempt;
    logic [28:0]                   tx_id;
    logic [63:0]                   tx_data;
  } batch_t;

endpackage

@@ hdl/carc_core.sv @@
module carc_core #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  carc_pkg::cfg_t    cfg_i,
  input  logic [1:0]        req_type_i,
  input  logic [28:0]       frame_id_i,
  input  logic [3:0]        frame_len_i,
  input  logic [63:0]       frame_data_i,
  input  logic              send_ok_i,
  output carc_pkg::batch_t  batch_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_DELAY   = 3'd1;
  localparam logic [2:0] PH_STATUS  = 3'd2;
  localparam logic [2:0] PH_ACKWAIT = 3'd3;
  localparam logic [2:0] PH_BACKOFF = 3'd4;

  localparam int unsigned CmpW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
  localparam logic [COUNTER_WIDTH-1:0] CntMax = {COUNTER_WIDTH{1'b1}};

  logic [2:0]               phase_q, phase_d;
  logic [7:0]               retry_q, retry_d;
  logic [COUNTER_WIDTH-1:0] tick_q, tick_d;
  logic [28:0]              held_id_q, held_id_d;
  logic [63:0]              held_data_q, held_data_d;

  logic [COUNTER_WIDTH-1:0] tick_inc;
  logic [28:0]              ack_id;
  logic                     go_delay;
  logic                     go_backoff;
  logic [2:0]               n;
  carc_pkg::batch_t         batch;

  assign tick_inc = (tick_q == CntMax) ? tick_q : tick_q + 1'b1;
  assign ack_id   = held_id_q + cfg_i.ack_id_offset;

  always_comb begin
    phase_d     = phase_q;
    retry_d     = retry_q;
    tick_d      = tick_q;
    held_id_d   = held_id_q;
    held_data_d = held_data_q;
    go_delay    = 1'b0;
    go_backoff  = 1'b0;
    n           = '0;
    batch       = '0;

    unique case (req_type_i)
      carc_pkg::REQ_SEND: begin
        if (phase_q != PH_IDLE) begin
          batch.code[n[1:0]]    = carc_pkg::EV_BUSY;
          batch.attempt[n[1:0]] = retry_q;
          n = n + 3'd1;
        end else begin
          held_id_d   = frame_id_i;
          held_data_d = frame_data_i;
          retry_d     = '0;
          go_delay    = 1'b1;
        end
      end
      carc_pkg::REQ_TICK: begin
        unique case (phase_q)
          PH_DELAY: begin
            tick_d = tick_inc;
            if (CmpW'(tick_inc) >= CmpW'(cfg_i.send_delay_ticks)) begin
              tick_d  = '0;
              phase_d = PH_STATUS;
              batch.code[n[1:0]]    = carc_pkg::EV_TRANSMIT;
              batch.attempt[n[1:0]] = retry_q;
              n = n + 3'd1;
            end
          end
          PH_ACKWAIT: begin
            tick_d = tick_inc;
            if (CmpW'(tick_inc) >= CmpW'(cfg_i.ack_timeout_ticks)) begin
              batch.code[n[1:0]]    = carc_pkg::EV_TIMEOUT;
              batch.attempt[n[1:0]] = retry_q;
              n = n + 3'd1;
              if (retry_q >= cfg_i.retry_limit) begin
                batch.code[n[1:0]]    = carc_pkg::EV_EXHAUSTED;
                batch.attempt[n[1:0]] = retry_q;
                n = n + 3'd1;
                phase_d = PH_IDLE;
                tick_d  = '0;
              end else begin
                retry_d = retry_q + 8'd1;
                batch.code[n[1:0]]    = carc_pkg::EV_RETRY;
                batch.attempt[n[1:0]] = retry_d;
                n = n + 3'd1;
                go_backoff = 1'b1;
              end
            end
          end
          PH_BACKOFF: begin
            tick_d = tick_inc;
            if (CmpW'(tick_inc) >= CmpW'(cfg_i.backoff_ticks)) go_delay = 1'b1;
          end
          default: ;
        endcase
      end
      carc_pkg::REQ_FRAME: begin
        if (phase_q == PH_ACKWAIT && frame_id_i == ack_id &&
            frame_len_i == carc_pkg::DLC_FULL && frame_data_i == held_data_q) begin
          batch.code[n[1:0]]    = carc_pkg::EV_ACKED;
          batch.attempt[n[1:0]] = retry_q;
          n = n + 3'd1;
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      end
      carc_pkg::REQ_STATUS: begin
        if (phase_q == PH_STATUS) begin
          batch.code[n[1:0]]    = carc_pkg::EV_SENT;
          batch.attempt[n[1:0]] = retry_q;
          n = n + 3'd1;
          tick_d = '0;
          batch.attempt[n[1:0]] = retry_q;
          if (!send_ok_i) begin
            batch.code[n[1:0]] = carc_pkg::EV_FAILED;
            phase_d = PH_IDLE;
          end else if (cfg_i.ack_enable) begin
            batch.code[n[1:0]] = carc_pkg::EV_ACKWAIT;
            phase_d = PH_ACKWAIT;
          end else begin
            batch.code[n[1:0]] = carc_pkg::EV_NOACK;
            phase_d = PH_IDLE;
          end
          n = n + 3'd1;
        end
      end
      default: ;
    endcase

    // backoff, possibly collapsing straight into the send delay
    if (go_backoff) begin
      tick_d = '0;
      if (cfg_i.backoff_ticks == '0) go_delay = 1'b1;
      else                           phase_d  = PH_BACKOFF;
    end

    // send delay, transmitting at once when it is zero
    if (go_delay) begin
      tick_d = '0;
      if (cfg_i.send_delay_ticks == '0) begin
        phase_d = PH_STATUS;
        batch.code[n[1:0]]    = carc_pkg::EV_TRANSMIT;
        batch.attempt[n[1:0]] = retry_d;
        n = n + 3'd1;
      end else begin
        phase_d = PH_DELAY;
      end
    end

    batch.count   = n;
    batch.tx_id   = held_id_d;
    batch.tx_data = held_data_d;
  end

  assign batch_o = batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      retry_q     <= '0;
      tick_q      <= '0;
      held_id_q   <= '0;
      held_data_q <= '0;
    end else if (commit_i) begin
      phase_q     <= phase_d;
      retry_q     <= retry_d;
      tick_q      <= tick_d;
      held_id_q   <= held_id_d;
      held_data_q <= held_data_d;
    end
  end

  // every way back to idle clears the tick count
  a_idle_tick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0)
    else $error("tick counter not clear in idle");

endmodule

@@ hdl/carc_emit.sv @@
module carc_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  carc_pkg::batch_t  batch_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        event_code_o,
  output logic [7:0]        attempt_index_o,
  output logic [28:0]       tx_id_o,
  output logic [63:0]       tx_data_o,
  output logic              last_o
);

  carc_pkg::batch_t batch_q;
  logic [2:0]       cnt_q;
  logic [1:0]       idx_q;
  logic             fire;
  logic             is_tx;

  assign out_valid_o = cnt_q != '0;
  assign last_o      = {1'b0, idx_q} == cnt_q - 3'd1;
  assign fire        = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (fire && last_o);

  assign event_code_o    = batch_q.code[idx_q];
  assign attempt_index_o = batch_q.attempt[idx_q];
  assign is_tx           = event_code_o == carc_pkg::EV_TRANSMIT;
  assign tx_id_o         = is_tx ? batch_q.tx_id : '0;
  assign tx_data_o       = is_tx ? batch_q.tx_data : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      idx_q <= '0;
    end else if (fire) begin
      if (last_o) cnt_q <= '0;
      else        idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) batch_q <= batch_i;
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> ({1'b0, idx_q} < cnt_q && cnt_q <= 3'd3))
    else $error("emitter index outside batch");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (free_o && batch_i.count != '0))
    else $error("batch loaded over unfinished one");

endmodule

@@ hdl/can_ack_retry_controller_unit.sv @@
// Stop-and-wait CAN sender with acknowledge, timeout and retry. Each request
// on the input channel (send, tick, received frame or link send status) is
// registered, decoded against the sender's phase and produces zero to three
// events, which leave one per cycle on the output channel while it is not
// stalled, with last set on the final one. Requests giving no event or one
// event flow back to back while the output is not stalled; a request giving
// several events holds the output until its last event has left, and the
// input stalls only once the event buffer is still busy with an earlier
// request. Registers are written through the cfg port (always ready) and
// must only be changed while the sender is quiet. Tick counting is
// COUNTER_WIDTH bits wide and saturates, so a delay the counter cannot
// reach never expires.
module can_ack_retry_controller_unit #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [63:0] frame_data_i,
  input  logic        send_ok_i,
  // event channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_code_o,
  output logic [7:0]  attempt_index_o,
  output logic [28:0] tx_id_o,
  output logic [63:0] tx_data_o,
  output logic        last_o
);

  // configuration registers, reset to the documented defaults
  carc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_enable        <= 1'b1;
      cfg_q.send_delay_ticks  <= 16'd5;
      cfg_q.ack_timeout_ticks <= 16'd50;
      cfg_q.backoff_ticks     <= 16'd10;
      cfg_q.retry_limit       <= 8'd2;
      cfg_q.ack_id_offset     <= 29'h80;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        carc_pkg::CFG_ACK_ENABLE:  cfg_q.ack_enable        <= cfg_data_i[0];
        carc_pkg::CFG_SEND_DELAY:  cfg_q.send_delay_ticks  <= cfg_data_i[15:0];
        carc_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_data_i[15:0];
        carc_pkg::CFG_BACKOFF:     cfg_q.backoff_ticks     <= cfg_data_i[15:0];
        carc_pkg::CFG_RETRY_LIMIT: cfg_q.retry_limit       <= cfg_data_i[7:0];
        carc_pkg::CFG_ACK_OFFSET:  cfg_q.ack_id_offset     <= cfg_data_i[28:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic [1:0]  req_type_q;
  logic [28:0] frame_id_q;
  logic [3:0]  frame_len_q;
  logic [63:0] frame_data_q;
  logic        send_ok_q;

  carc_pkg::batch_t batch;
  logic             emit_free;
  logic             advance;
  logic             in_take;

  // a request moves on once its events (if any) fit in the emitter
  assign advance    = in_valid_q && (batch.count == '0 || emit_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q   <= req_type_i;
      frame_id_q   <= frame_id_i;
      frame_len_q  <= frame_len_i;
      frame_data_q <= frame_data_i;
      send_ok_q    <= send_ok_i;
    end
  end

  carc_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (advance),
    .cfg_i       (cfg_q),
    .req_type_i  (req_type_q),
    .frame_id_i  (frame_id_q),
    .frame_len_i (frame_len_q),
    .frame_data_i(frame_data_q),
    .send_ok_i   (send_ok_q),
    .batch_o     (batch)
  );

  carc_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && batch.count != '0),
    .batch_i        (batch),
    .free_o         (emit_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .attempt_index_o(attempt_index_o),
    .tx_id_o        (tx_id_o),
    .tx_data_o      (tx_data_o),
    .last_o         (last_o)
  );

  // an empty input register never holds the request channel off
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("request stalled with empty input register");

endmodule
